FILE: src/rclq_pkg.sv
// Package for the request coalescing load queue.
// Holds entry and result types, state encoding, command, kind, phase and status codes.
package rclq_pkg;
  localparam int DEPTH_DEF = 16;
  localparam int CNT_W = 5;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_DONE = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_ISSUED = 2'd2;
  localparam logic [1:0] PH_CANCEL = 2'd3;

  localparam logic [2:0] K_ISSUE = 3'd0;
  localparam logic [2:0] K_COMPLETE = 3'd1;
  localparam logic [2:0] K_REJECT = 3'd2;
  localparam logic [2:0] K_UNLOAD = 3'd3;
  localparam logic [2:0] K_COUNT = 3'd4;

  localparam logic [3:0] ST_CANCEL_WAIT = 4'd3;
  localparam logic [3:0] ST_CANCEL_ISSUED = 4'd4;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  req;
    logic [31:0] flags;
    logic [1:0]  phase;
  } entry_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       req;
    logic [31:0]      key;
    logic [31:0]      flags;
    logic [31:0]      result;
    logic [3:0]       status;
    logic [CNT_W-1:0] count;
  } item_t;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_HEAD, S_CNT, S_FIN} state_t;
endpackage

FILE: src/request_coalescing_load_queue.sv
// Request coalescing load queue: top level, single module.
// Depends on rclq_pkg; entries live in one synchronous memory.
// Every command raises busy until its last word is out. Add walks the queue
// for duplicates; completion, when its requester heads the queue, and cancel
// walk all queued entries and compact the memory in place, each entry passing
// through a read state and then an evaluate state on the registered read.
// Result words appear on out_* for one cycle each with out_valid high; the
// receiver cannot stall them, and out_last marks the final word of a command.
module request_coalescing_load_queue #(
  parameter int QUEUE_DEPTH = rclq_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_cmd,
  input  logic [31:0]               in_name_key,
  input  logic [7:0]                in_requester,
  input  logic [31:0]               in_load_flags,
  input  logic [31:0]               in_load_result,
  input  logic [3:0]                in_load_status,
  output logic                      out_valid,
  output logic [2:0]                out_kind,
  output logic [7:0]                out_requester,
  output logic [31:0]               out_key,
  output logic [31:0]               out_flags,
  output logic [31:0]               out_result,
  output logic [3:0]                out_status,
  output logic [rclq_pkg::CNT_W-1:0] out_cancel_count,
  output logic                      out_last
);
  import rclq_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt, i_r, i_nxt, w_r, w_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [31:0] key_r, key_nxt, flags_r, flags_nxt, res_r, res_nxt;
  logic [7:0] req_r, req_nxt;
  logic [3:0] st_r, st_nxt;
  logic [31:0] hk_r, hk_nxt;
  logic [1:0] cp_r, cp_nxt;
  logic unl_r, unl_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  entry_t head_r, head_nxt;
  logic head_v_r, head_v_nxt;
  item_t pend_r, pend_nxt;
  logic pend_v_r, pend_v_nxt;
  item_t out_r, out_nxt;
  logic out_v_r, out_v_nxt, last_r, last_nxt;

  logic we;
  logic [IW-1:0] waddr;
  entry_t wdata;
  logic emit;
  item_t eitem;

  logic [31:0] hk_e;
  logic [1:0] cp_e;
  logic keep;
  entry_t ke;
  logic at_end;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[i_r[IW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; i_nxt = i_r; w_nxt = w_r;
    cmd_nxt = cmd_r; key_nxt = key_r; flags_nxt = flags_r; res_nxt = res_r;
    req_nxt = req_r; st_nxt = st_r; hk_nxt = hk_r; cp_nxt = cp_r;
    unl_nxt = unl_r; cnt_nxt = cnt_r; head_nxt = head_r; head_v_nxt = head_v_r;
    we = 1'b0; waddr = '0; wdata = rdata_r;
    emit = 1'b0; eitem = '0;
    hk_e = (i_r == '0) ? rdata_r.key : hk_r;
    cp_e = (i_r == '0) ? rdata_r.phase : cp_r;
    keep = 1'b1; ke = rdata_r;
    at_end = (i_r == len_r - LW'(1));
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd; key_nxt = in_name_key; req_nxt = in_requester;
          flags_nxt = in_load_flags; res_nxt = in_load_result; st_nxt = in_load_status;
          i_nxt = '0; w_nxt = '0; unl_nxt = 1'b0; cnt_nxt = '0; head_v_nxt = 1'b0;
          state_nxt = S_FIN;
          unique case (in_cmd)
            CMD_ADD: begin
              if (len_r >= DEPTH_L) begin
                emit = 1'b1; eitem.kind = K_REJECT; eitem.req = in_requester;
              end else if (len_r == '0) begin
                we = 1'b1; waddr = '0;
                wdata = '{key: in_name_key, req: in_requester,
                          flags: in_load_flags, phase: PH_ISSUED};
                len_nxt = LW'(1);
                emit = 1'b1; eitem.kind = K_ISSUE; eitem.req = in_requester;
                eitem.key = in_name_key; eitem.flags = in_load_flags;
              end else begin
                state_nxt = S_RD;
              end
            end
            CMD_DONE: begin
              if (len_r != '0) state_nxt = S_RD;
            end
            CMD_CANCEL: begin
              if (len_r == '0) state_nxt = S_CNT;
              else state_nxt = S_RD;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        hk_nxt = hk_e; cp_nxt = cp_e;
        state_nxt = S_RD;
        i_nxt = i_r + LW'(1);
        unique case (cmd_r)
          CMD_ADD: begin
            keep = 1'b0;
            if (rdata_r.req == req_r) begin
              state_nxt = S_FIN;
            end else if (at_end) begin
              we = 1'b1; waddr = len_r[IW-1:0];
              wdata = '{key: key_r, req: req_r, flags: flags_r, phase: PH_WAIT};
              len_nxt = len_r + LW'(1);
              state_nxt = S_FIN;
            end
          end
          CMD_DONE: begin
            if (i_r == '0 && rdata_r.req != req_r) begin
              keep = 1'b0;
              state_nxt = S_FIN;
            end else if (i_r == '0 && cp_e == PH_CANCEL && res_r != '0 && !unl_r) begin
              keep = 1'b0;
              unl_nxt = 1'b1;
              emit = 1'b1; eitem.kind = K_UNLOAD; eitem.result = res_r;
              i_nxt = i_r;
              state_nxt = S_EV;
            end else if (rdata_r.key == hk_e &&
                         !(cp_e == PH_CANCEL && rdata_r.phase == PH_WAIT)) begin
              keep = 1'b0;
              emit = 1'b1; eitem.kind = K_COMPLETE; eitem.req = rdata_r.req;
              if (cp_e == PH_ISSUED &&
                  (rdata_r.phase == PH_ISSUED || rdata_r.phase == PH_WAIT)) begin
                eitem.result = res_r; eitem.status = st_r;
              end else begin
                eitem.status = ST_CANCEL_ISSUED;
              end
            end
          end
          default: begin
            if (rdata_r.key == key_r) begin
              cnt_nxt = cnt_r + CNT_W'(1);
              if (key_r == hk_e) begin
                ke.phase = PH_CANCEL;
              end else begin
                keep = 1'b0;
                emit = 1'b1; eitem.kind = K_COMPLETE; eitem.req = rdata_r.req;
                eitem.status = ST_CANCEL_WAIT;
              end
            end
          end
        endcase
        if (cmd_r != CMD_ADD && state_nxt == S_RD) begin
          if (keep) begin
            we = 1'b1; waddr = w_r[IW-1:0]; wdata = ke;
            w_nxt = w_r + LW'(1);
            if (w_r == '0) begin
              head_nxt = ke; head_v_nxt = 1'b1;
            end
          end
          if (at_end) begin
            len_nxt = keep ? w_r + LW'(1) : w_r;
            if (cmd_r == CMD_DONE) begin
              state_nxt = ((keep && w_r == '0) ? ke.phase == PH_WAIT :
                           (head_v_r && head_r.phase == PH_WAIT)) ? S_HEAD : S_FIN;
              if (keep && w_r == '0) begin
                head_nxt = ke;
              end
            end else begin
              state_nxt = S_CNT;
            end
          end
        end
      end
      S_HEAD: begin
        we = 1'b1; waddr = '0;
        wdata = head_r; wdata.phase = PH_ISSUED;
        emit = 1'b1; eitem.kind = K_ISSUE; eitem.req = head_r.req;
        eitem.key = head_r.key; eitem.flags = head_r.flags;
        state_nxt = S_FIN;
      end
      S_CNT: begin
        emit = 1'b1; eitem.kind = K_COUNT; eitem.count = cnt_r;
        state_nxt = S_FIN;
      end
      S_FIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pend_nxt = pend_r; pend_v_nxt = pend_v_r;
    out_nxt = pend_r; out_v_nxt = 1'b0; last_nxt = 1'b0;
    if (emit) begin
      out_v_nxt = pend_v_r;
      pend_nxt = eitem; pend_v_nxt = 1'b1;
    end else if (state_r == S_FIN) begin
      out_v_nxt = pend_v_r; last_nxt = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
      unl_r <= 1'b0;
      head_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r <= out_v_nxt;
      unl_r <= unl_nxt;
      head_v_r <= head_v_nxt;
    end
    i_r <= i_nxt; w_r <= w_nxt; cmd_r <= cmd_nxt; key_r <= key_nxt;
    flags_r <= flags_nxt; res_r <= res_nxt; req_r <= req_nxt; st_r <= st_nxt;
    hk_r <= hk_nxt; cp_r <= cp_nxt; cnt_r <= cnt_nxt; head_r <= head_nxt;
    pend_r <= pend_nxt; out_r <= out_nxt; last_r <= last_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_kind = out_r.kind;
  assign out_requester = out_r.req;
  assign out_key = out_r.key;
  assign out_flags = out_r.flags;
  assign out_result = out_r.result;
  assign out_status = out_r.status;
  assign out_cancel_count = out_r.count;
  assign out_last = last_r;
endmodule

FILE: tb/request_coalescing_load_queue_tb.sv
// Self-checking testbench for request_coalescing_load_queue.
// Depends on rclq_pkg; predicts each command's result words from a local copy of
// the queue and checks every strobed word in order.
module request_coalescing_load_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rclq_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int LIMIT = 400000;
  localparam int TAIL = 2 * DEPTH + 20;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [7:0]  req;
    logic [31:0] flags;
    logic [31:0] result;
    logic [3:0]  status;
    bit          to_head;
    bit          to_queued_key;
    bit          drain;
    int          gap;
  } cmd_word_t;

  typedef struct {
    item_t it;
    bit    last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = '0;
  logic [31:0] in_name_key = '0;
  logic [7:0] in_requester = '0;
  logic [31:0] in_load_flags = '0;
  logic [31:0] in_load_result = '0;
  logic [3:0] in_load_status = '0;
  logic out_valid;
  logic [2:0] out_kind;
  logic [7:0] out_requester;
  logic [31:0] out_key;
  logic [31:0] out_flags;
  logic [31:0] out_result;
  logic [3:0] out_status;
  logic [CNT_W-1:0] out_cancel_count;
  logic out_last;

  request_coalescing_load_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_name_key(in_name_key), .in_requester(in_requester),
    .in_load_flags(in_load_flags), .in_load_result(in_load_result),
    .in_load_status(in_load_status), .out_valid(out_valid), .out_kind(out_kind),
    .out_requester(out_requester), .out_key(out_key), .out_flags(out_flags),
    .out_result(out_result), .out_status(out_status),
    .out_cancel_count(out_cancel_count), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the load queue
  int unsigned q_len;
  logic [31:0] q_key [DEPTH];
  logic [7:0]  q_req [DEPTH];
  logic [31:0] q_flags [DEPTH];
  logic [1:0]  q_phase [DEPTH];

  cmd_word_t pending_words[$];
  result_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;

  task automatic push_result(logic [2:0] kind, logic [7:0] req, logic [31:0] key,
                             logic [31:0] flags, logic [31:0] result,
                             logic [3:0] status, logic [CNT_W-1:0] count);
    result_word_t w;
    w.it.kind = kind;
    w.it.req = req;
    w.it.key = key;
    w.it.flags = flags;
    w.it.result = result;
    w.it.status = status;
    w.it.count = count;
    w.last = 1'b0;
    expected_words.push_back(w);
  endtask

  task automatic remove_entry(int unsigned i);
    for (int unsigned j = i; j + 1 < q_len; j++) begin
      q_key[j] = q_key[j+1];
      q_req[j] = q_req[j+1];
      q_flags[j] = q_flags[j+1];
      q_phase[j] = q_phase[j+1];
    end
    if (q_len > 0) q_len--;
  endtask

  task automatic issue_head();
    if (q_len > 0 && q_phase[0] == PH_WAIT) begin
      q_phase[0] = PH_ISSUED;
      push_result(K_ISSUE, q_req[0], q_key[0], q_flags[0], '0, '0, '0);
    end
  endtask

  task automatic predict_queue(cmd_word_t w);
    int unsigned n0;
    int unsigned i;
    logic [31:0] hk;
    logic [1:0] hp;
    logic [1:0] ph;
    int unsigned count;
    bit dup;
    result_word_t t;
    n0 = expected_words.size();
    case (w.cmd)
      CMD_ADD: begin
        if (q_len >= DEPTH) begin
          push_result(K_REJECT, w.req, '0, '0, '0, '0, '0);
        end else begin
          dup = 0;
          for (i = 0; i < q_len; i++) if (q_req[i] == w.req) dup = 1;
          if (!dup) begin
            q_key[q_len] = w.key;
            q_req[q_len] = w.req;
            q_flags[q_len] = w.flags;
            q_phase[q_len] = PH_WAIT;
            q_len++;
            issue_head();
          end
        end
      end
      CMD_DONE: begin
        if (q_len > 0 && q_req[0] == w.req) begin
          hk = q_key[0];
          hp = q_phase[0];
          if (hp == PH_CANCEL && w.result != 0)
            push_result(K_UNLOAD, '0, '0, '0, w.result, '0, '0);
          i = 0;
          while (i < q_len) begin
            ph = q_phase[i];
            if (q_key[i] == hk && hp == PH_ISSUED && (ph == PH_ISSUED || ph == PH_WAIT)) begin
              push_result(K_COMPLETE, q_req[i], '0, '0, w.result, w.status, '0);
              remove_entry(i);
            end else if (q_key[i] == hk && (hp != PH_CANCEL || ph != PH_WAIT)) begin
              push_result(K_COMPLETE, q_req[i], '0, '0, '0, ST_CANCEL_ISSUED, '0);
              remove_entry(i);
            end else begin
              i++;
            end
          end
          issue_head();
        end
      end
      CMD_CANCEL: begin
        count = 0;
        if (q_len > 0) begin
          hk = q_key[0];
          i = 0;
          while (i < q_len) begin
            if (q_key[i] == w.key) begin
              count++;
              if (w.key == hk) begin
                q_phase[i] = PH_CANCEL;
                i++;
              end else begin
                push_result(K_COMPLETE, q_req[i], '0, '0, '0, ST_CANCEL_WAIT, '0);
                remove_entry(i);
              end
            end else begin
              i++;
            end
          end
        end
        push_result(K_COUNT, '0, '0, '0, '0, '0, CNT_W'(count));
      end
      default: ;
    endcase
    if (expected_words.size() > n0) begin
      t = expected_words[expected_words.size()-1];
      t.last = 1'b1;
      expected_words[expected_words.size()-1] = t;
    end
  endtask

  // Driver
  cmd_word_t cur;
  bit have_word = 0;
  bit draining = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic nxt_start;
    bit fire;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      nxt_start = start && !fire;
      if (fire) predict_queue(cur);
      if (!nxt_start) begin
        if (draining) begin
          if (!fire && !busy && expected_words.size() == 0) draining = 0;
        end else if (!have_word && pending_words.size() > 0) begin
          cur = pending_words.pop_front();
          if (cur.drain) draining = 1;
          else begin
            have_word = 1;
            gap_left = cur.gap;
          end
        end
        if (have_word && !draining) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            if (cur.to_head && q_len > 0) cur.req = q_req[0];
            if (cur.to_queued_key && q_len > 0) cur.key = q_key[$urandom_range(0, q_len - 1)];
            in_cmd <= cur.cmd;
            in_name_key <= cur.key;
            in_requester <= cur.req;
            in_load_flags <= cur.flags;
            in_load_result <= cur.result;
            in_load_status <= cur.status;
            nxt_start = 1'b1;
            have_word = 0;
          end
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor
  always @(posedge clk) begin
    result_word_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("request_coalescing_load_queue_tb: FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: kind=%0d req=%0d result=%h", $time,
                 out_kind, out_requester, out_result);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_kind !== e.it.kind || out_requester !== e.it.req || out_key !== e.it.key ||
            out_flags !== e.it.flags || out_result !== e.it.result ||
            out_status !== e.it.status || out_cancel_count !== e.it.count ||
            out_last !== e.last) begin
          $display("%0t mismatch exp: kind=%0d req=%0d key=%h flags=%h res=%h st=%0d cnt=%0d last=%0d",
                   $time, e.it.kind, e.it.req, e.it.key, e.it.flags, e.it.result,
                   e.it.status, e.it.count, e.last);
          $display("%0t          got: kind=%0d req=%0d key=%h flags=%h res=%h st=%0d cnt=%0d last=%0d",
                   $time, out_kind, out_requester, out_key, out_flags, out_result,
                   out_status, out_cancel_count, out_last);
          errors++;
        end
      end
    end
  end

  // Stimulus
  logic [31:0] key_pool [6];

  function automatic cmd_word_t make_word(logic [1:0] cmd, logic [31:0] key, logic [7:0] req,
                                          logic [31:0] flags, logic [31:0] result,
                                          logic [3:0] status);
    cmd_word_t w;
    w.cmd = cmd;
    w.key = key;
    w.req = req;
    w.flags = flags;
    w.result = result;
    w.status = status;
    w.to_head = 0;
    w.to_queued_key = 0;
    w.drain = 0;
    w.gap = 0;
    return w;
  endfunction

  function automatic cmd_word_t random_word(bit quiet);
    cmd_word_t w;
    int unsigned pick;
    logic [7:0] req;
    req = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
    w = make_word(CMD_ADD, key_pool[$urandom_range(0, 5)], req, $urandom,
                  ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom),
                  4'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 50) w.cmd = CMD_ADD;
    else if (pick < 78) begin
      w.cmd = CMD_DONE;
      w.to_head = ($urandom_range(0, 9) != 0);
    end else if (pick < 95) begin
      w.cmd = CMD_CANCEL;
      w.to_queued_key = ($urandom_range(0, 9) < 7);
    end else w.cmd = CMD_NONE;
    if (!quiet && $urandom_range(0, 3) == 0) w.gap = $urandom_range(1, 17);
    return w;
  endfunction

  initial begin
    cmd_word_t w;
    for (int k = 0; k < 4; k++) key_pool[k] = $urandom;
    key_pool[4] = 32'h0;
    key_pool[5] = 32'hFFFF_FFFF;

    // directed
    pending_words.push_back(make_word(CMD_CANCEL, 32'h1234, 8'd0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_DONE, 0, 8'd1, 0, 32'h5, 4'd2));
    pending_words.push_back(make_word(CMD_ADD, 32'h0, 8'd0, 32'hFFFF_FFFF, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 32'h0, 8'd255, 32'h0, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 32'hFFFF_FFFF, 8'd7, 32'hA5A5_5A5A, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 32'h0, 8'd255, 32'h1, 0, 0));
    pending_words.push_back(make_word(CMD_DONE, 0, 8'd7, 0, 32'hDEAD, 4'd1));
    pending_words.push_back(make_word(CMD_NONE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 4'hF));
    pending_words.push_back(make_word(CMD_DONE, 0, 8'd0, 0, 32'hFFFF_FFFF, 4'hF));
    pending_words.push_back(make_word(CMD_ADD, 32'h77, 8'd3, 32'h3, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 32'h77, 8'd4, 32'h4, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 32'h88, 8'd5, 32'h5, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 32'h77, 8'd6, 32'h6, 0, 0));
    pending_words.push_back(make_word(CMD_CANCEL, 32'h88, 8'd0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_CANCEL, 32'h77, 8'd0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 32'h77, 8'd9, 32'h9, 0, 0));
    pending_words.push_back(make_word(CMD_DONE, 0, 8'd3, 0, 32'h1234_5678, 4'd0));
    pending_words.push_back(make_word(CMD_ADD, 32'h99, 8'd10, 32'h10, 0, 0));
    pending_words.push_back(make_word(CMD_CANCEL, 32'h99, 8'd0, 0, 0, 0));
    pending_words.push_back(make_word(CMD_DONE, 0, 8'd10, 0, 32'h0, 4'd8));
    pending_words.push_back(make_word(CMD_DONE, 0, 8'd9, 0, 32'h0, 4'd8));
    for (int k = 0; k < 17; k++)
      pending_words.push_back(make_word(CMD_ADD, key_pool[k % 3], 8'(k + 100), $urandom, 0, 0));
    w = make_word(CMD_ADD, 0, 0, 0, 0, 0);
    w.drain = 1;
    pending_words.push_back(w);

    // random
    for (int k = 0; k < 480; k++) begin
      if (k == 160 || k == 320) pending_words.push_back(w);
      pending_words.push_back(random_word(k >= 420));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_words.size() > 0 || have_word || draining || start || busy ||
           expected_words.size() > 0);
    repeat (TAIL) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("request_coalescing_load_queue_tb: PASS");
    end else begin
      $display("request_coalescing_load_queue_tb: FAIL");
    end
    $finish;
  end
endmodule

FILE: request_coalescing_load_queue.f
src/rclq_pkg.sv
src/request_coalescing_load_queue.sv
tb/request_coalescing_load_queue_tb.sv
